### hw/rtl/etba_pkg.sv
`default_nettype none

package etba_pkg;

	localparam int PROD_W = 32;
	localparam int DSR_W = 25;
	localparam int CFG_W = 22;

	localparam logic [15:0] WTC_RESET = 16'd100;
	localparam logic [15:0] RADIUS_RESET = 16'd35;
	localparam logic [15:0] CPR_RESET = 16'd360;
	localparam logic [21:0] TIMEOUT_RESET = 22'h300000;

	localparam logic [15:0] DEG_FULL = 16'd360;
	localparam logic [6:0] CURVE_DELTA = 7'd10;
	localparam logic [6:0] DUTY_MAX = 7'd127;

	localparam logic [3:0] DIR_BACK = 4'd1;
	localparam logic [3:0] DIR_CCW = 4'd3;
	localparam logic [3:0] DIR_FWD_LEFT = 4'd4;
	localparam logic [3:0] DIR_FWD_RIGHT = 4'd5;
	localparam logic [3:0] DIR_BACK_LEFT = 4'd6;
	localparam logic [3:0] DIR_BACK_RIGHT = 4'd7;

	localparam logic MODE_START = 1'b0;

	localparam logic [1:0] STAT_NONE = 2'd0;
	localparam logic [1:0] STAT_DONE = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		REG_WHEEL_TO_CENTER = 2'd0,
		REG_WHEEL_RADIUS = 2'd1,
		REG_COUNTS_PER_REV = 2'd2,
		REG_TIMEOUT_TICKS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic mode;
		logic [15:0] turn_angle;
		logic [3:0] direction;
		logic [6:0] speed;
		logic left_pulse;
		logic right_pulse;
	} cmd_t;

	typedef struct packed {
		logic [6:0] left_duty;
		logic [6:0] right_duty;
		logic left_reverse;
		logic right_reverse;
		logic turning;
		logic [1:0] turn_status;
		logic [15:0] target_count;
		logic [15:0] left_count;
		logic [15:0] right_count;
	} rsp_t;

endpackage

`default_nettype wire

### hw/rtl/etba_div.sv
`default_nettype none

module etba_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [etba_pkg::PROD_W-1:0] dividend,
	input wire logic [etba_pkg::DSR_W-1:0] divisor,
	output logic done,
	output logic [etba_pkg::PROD_W-1:0] quotient
);
	import etba_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic run_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [PROD_W-1:0] quo_q;

	logic [DSR_W:0] shifted;
	logic [DSR_W:0] diff;
	logic fits;

	// one restoring step per cycle; a zero divisor always fits, giving all ones
	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign diff = shifted - {1'b0, dsr_q};
	assign fits = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(PROD_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### hw/rtl/encoder_turn_by_angle.sv
// Two-wheel turn sequencer.
// Input channel cmd (valid/ready) carries one beat per item: mode 0 starts a
// turn from turn_angle, direction and speed; mode 1 is a time tick that adds
// the left and right encoder pulses. Every beat gives exactly one rsp beat
// with the wheel duties, reverse bits, turn state and encoder counts.
// cfg_we/cfg_addr/cfg_wdata write the geometry and timeout registers; write
// them only while no item is in flight.
// Tick: result is registered and valid in the cycle after acceptance; ticks
// sustain one per cycle while the receiver keeps rsp_ready high.
// Start: one 32x16 multiplier is used three times (angle*distance, *counts,
// 360*radius), then a restoring divider retires one quotient bit per cycle;
// cmd_ready stays low throughout.
// cmd_ready is high only when the sequencer is idle and the output register
// is empty or being drained, so a stalled receiver holds off further beats.
// Reset: registers go to their defaults, counts, target and duties to zero,
// no turn running, no result pending.
`default_nettype none

module encoder_turn_by_angle #(
	parameter int COUNT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire etba_pkg::cmd_t cmd,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output etba_pkg::rsp_t rsp,
	input wire logic cfg_we,
	input wire etba_pkg::reg_idx_t cfg_addr,
	input wire logic [etba_pkg::CFG_W-1:0] cfg_wdata
);
	import etba_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL_A = 6'b000010,
		ST_MUL_B = 6'b000100,
		ST_MUL_C = 6'b001000,
		ST_DIV_GO = 6'b010000,
		ST_DIV_WAIT = 6'b100000
	} state_t;

	state_t state_q;

	logic [15:0] wtc_q;
	logic [15:0] radius_q;
	logic [15:0] cpr_q;
	logic [21:0] timeout_q;

	logic [COUNT_BITS-1:0] target_q;
	logic [COUNT_BITS-1:0] lcnt_q;
	logic [COUNT_BITS-1:0] rcnt_q;
	logic [21:0] ticks_q;
	logic busy_q;
	logic [6:0] lduty_q;
	logic [6:0] rduty_q;
	logic lrev_q;
	logic rrev_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [15:0] angle_q;
	logic [3:0] dir_q;
	logic [6:0] speed_q;

	logic [PROD_W-1:0] mul_q;
	logic [PROD_W-1:0] dvd_q;
	logic [PROD_W-1:0] mul_a;
	logic [15:0] mul_b;
	logic [PROD_W+15:0] mul_p;

	logic div_start;
	logic div_done;
	logic [PROD_W-1:0] div_quo;

	logic accept;
	logic tick_go;
	logic fin_go;
	logic slot_free;

	logic [COUNT_BITS-1:0] lcnt_n;
	logic [COUNT_BITS-1:0] rcnt_n;
	logic [COUNT_BITS-1:0] target_n;
	logic [21:0] ticks_n;
	logic busy_n;
	logic [1:0] stat_n;
	logic [6:0] lduty_n;
	logic [6:0] rduty_n;
	logic lrev_n;
	logic rrev_n;

	logic [6:0] duty_lo;
	logic [7:0] duty_sum;
	logic [6:0] duty_hi;
	logic [31:0] tgt_ext;
	logic [31:0] lcnt_ext;
	logic [31:0] rcnt_ext;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_IDLE) && slot_free;
	assign accept = cmd_valid && cmd_ready;
	assign tick_go = accept && (cmd.mode != MODE_START);
	assign fin_go = (state_q == ST_DIV_WAIT) && div_done;
	assign div_start = (state_q == ST_DIV_GO);

	// shared multiplier, low 32 bits kept
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_A: begin
				mul_a = PROD_W'(angle_q);
				mul_b = wtc_q;
			end
			ST_MUL_B: begin
				mul_a = mul_q;
				mul_b = cpr_q;
			end
			ST_MUL_C: begin
				mul_a = PROD_W'(radius_q);
				mul_b = DEG_FULL;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {16'b0, mul_a} * {{PROD_W{1'b0}}, mul_b};

	etba_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dvd_q),
		.divisor(mul_q[DSR_W-1:0]),
		.done(div_done),
		.quotient(div_quo)
	);

	// curve-mode duties
	assign duty_lo = (speed_q > CURVE_DELTA) ? (speed_q - CURVE_DELTA) : 7'd0;
	assign duty_sum = {1'b0, speed_q} + {1'b0, CURVE_DELTA};
	assign duty_hi = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[6:0];

	always_comb begin
		lcnt_n = lcnt_q;
		rcnt_n = rcnt_q;
		target_n = target_q;
		ticks_n = ticks_q;
		busy_n = busy_q;
		stat_n = STAT_NONE;
		lduty_n = lduty_q;
		rduty_n = rduty_q;
		lrev_n = lrev_q;
		rrev_n = rrev_q;
		if (fin_go) begin
			target_n = div_quo[COUNT_BITS-1:0];
			lcnt_n = '0;
			rcnt_n = '0;
			ticks_n = timeout_q;
			lduty_n = speed_q;
			rduty_n = speed_q;
			lrev_n = 1'b0;
			rrev_n = 1'b0;
			unique case (dir_q)
				DIR_BACK: begin
					lrev_n = 1'b1;
					rrev_n = 1'b1;
				end
				DIR_CCW: lrev_n = 1'b1;
				DIR_FWD_LEFT: lduty_n = duty_lo;
				DIR_FWD_RIGHT: rduty_n = duty_lo;
				DIR_BACK_LEFT: begin
					rduty_n = duty_hi;
					lrev_n = 1'b1;
					rrev_n = 1'b1;
				end
				DIR_BACK_RIGHT: begin
					lduty_n = duty_hi;
					lrev_n = 1'b1;
					rrev_n = 1'b1;
				end
				default: rrev_n = 1'b1;
			endcase
			if (target_n == '0) begin
				busy_n = 1'b0;
				stat_n = STAT_DONE;
			end else begin
				busy_n = 1'b1;
			end
		end else if (tick_go) begin
			lcnt_n = lcnt_q + COUNT_BITS'(cmd.left_pulse);
			rcnt_n = rcnt_q + COUNT_BITS'(cmd.right_pulse);
			if (busy_q) begin
				priority if (lcnt_n >= target_q || rcnt_n >= target_q) begin
					busy_n = 1'b0;
					stat_n = STAT_DONE;
				end else if (ticks_q <= 22'd1) begin
					ticks_n = '0;
					busy_n = 1'b0;
					stat_n = STAT_TIMEOUT;
				end else begin
					ticks_n = ticks_q - 22'd1;
				end
			end
		end
	end

	assign tgt_ext = 32'(target_n);
	assign lcnt_ext = 32'(lcnt_n);
	assign rcnt_ext = 32'(rcnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wtc_q <= WTC_RESET;
			radius_q <= RADIUS_RESET;
			cpr_q <= CPR_RESET;
			timeout_q <= TIMEOUT_RESET;
			target_q <= '0;
			lcnt_q <= '0;
			rcnt_q <= '0;
			ticks_q <= '0;
			busy_q <= 1'b0;
			lduty_q <= '0;
			rduty_q <= '0;
			lrev_q <= 1'b0;
			rrev_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_WHEEL_TO_CENTER: wtc_q <= cfg_wdata[15:0];
					REG_WHEEL_RADIUS: radius_q <= cfg_wdata[15:0];
					REG_COUNTS_PER_REV: cpr_q <= cfg_wdata[15:0];
					REG_TIMEOUT_TICKS: timeout_q <= cfg_wdata;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: if (accept && cmd.mode == MODE_START) state_q <= ST_MUL_A;
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_MUL_C;
				ST_MUL_C: state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: if (div_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			target_q <= target_n;
			lcnt_q <= lcnt_n;
			rcnt_q <= rcnt_n;
			ticks_q <= ticks_n;
			busy_q <= busy_n;
			lduty_q <= lduty_n;
			rduty_q <= rduty_n;
			lrev_q <= lrev_n;
			rrev_q <= rrev_n;

			if (tick_go || fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle_q <= cmd.turn_angle;
			dir_q <= cmd.direction;
			speed_q <= cmd.speed;
		end
		mul_q <= mul_p[PROD_W-1:0];
		if (state_q == ST_MUL_C) begin
			dvd_q <= mul_q;
		end
		if (tick_go || fin_go) begin
			rsp_q.left_duty <= lduty_n;
			rsp_q.right_duty <= rduty_n;
			rsp_q.left_reverse <= lrev_n;
			rsp_q.right_reverse <= rrev_n;
			rsp_q.turning <= busy_n;
			rsp_q.turn_status <= stat_n;
			rsp_q.target_count <= tgt_ext[15:0];
			rsp_q.left_count <= lcnt_ext[15:0];
			rsp_q.right_count <= rcnt_ext[15:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> state_q == ST_IDLE)
		else $error("cmd_ready while sequencer is busy");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> rsp_valid_q)
		else $error("finished start gave no result beat");

	a_busy_target: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> target_q != '0)
		else $error("turn running with zero target");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider done outside wait state");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DIV_WAIT) |-> !tick_go)
		else $error("tick accepted during a start sequence");

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
	import etba_pkg::*;

	localparam int HANG_LIMIT = 1000;
	localparam int REPORT_MAX = 10;
	localparam logic MODE_TICK = 1'b1;
	localparam logic [3:0] DIR_CW = 4'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_addr = REG_WHEEL_TO_CENTER;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// register copies and sequencer state as the testbench sees them
	logic [15:0] geo_wtc = WTC_RESET;
	logic [15:0] geo_radius = RADIUS_RESET;
	logic [15:0] geo_cpr = CPR_RESET;
	logic [21:0] geo_timeout = TIMEOUT_RESET;
	logic [15:0] sim_target = '0;
	logic [15:0] sim_left = '0;
	logic [15:0] sim_right = '0;
	logic [21:0] sim_ticks = '0;
	logic sim_busy = 1'b0;
	logic [6:0] sim_lduty = '0;
	logic [6:0] sim_rduty = '0;
	logic sim_lrev = 1'b0;
	logic sim_rrev = 1'b0;

	rsp_t pending_turn_rsps[$];
	int fault_count = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	logic calm = 1'b0;
	logic [15:0] stall_pat = '1;
	int stall_pos = 0;

	encoder_turn_by_angle dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [6:0] slower_duty(logic [6:0] s);
		return (s > CURVE_DELTA) ? s - CURVE_DELTA : 7'd0;
	endfunction

	function automatic logic [6:0] faster_duty(logic [6:0] s);
		logic [7:0] v;
		v = {1'b0, s} + {1'b0, CURVE_DELTA};
		return (v > {1'b0, DUTY_MAX}) ? DUTY_MAX : v[6:0];
	endfunction

	// advances the sequencer state by one beat and returns the result it drives
	function automatic rsp_t advance_turn(cmd_t c);
		logic [63:0] full;
		logic [31:0] divisor;
		logic [31:0] quot;
		logic [1:0] status;
		rsp_t r;
		status = STAT_NONE;
		if (c.mode == MODE_START) begin
			full = {48'b0, c.turn_angle} * {48'b0, geo_wtc} * {48'b0, geo_cpr};
			divisor = 32'd360 * {16'b0, geo_radius};
			quot = (divisor == 32'd0) ? '1 : full[31:0] / divisor;
			sim_target = quot[15:0];
			sim_left = '0;
			sim_right = '0;
			sim_ticks = geo_timeout;
			sim_lduty = c.speed;
			sim_rduty = c.speed;
			sim_lrev = 1'b0;
			sim_rrev = 1'b0;
			case (c.direction)
				DIR_BACK: begin
					sim_lrev = 1'b1;
					sim_rrev = 1'b1;
				end
				DIR_CCW: sim_lrev = 1'b1;
				DIR_FWD_LEFT: sim_lduty = slower_duty(c.speed);
				DIR_FWD_RIGHT: sim_rduty = slower_duty(c.speed);
				DIR_BACK_LEFT: begin
					sim_rduty = faster_duty(c.speed);
					sim_lrev = 1'b1;
					sim_rrev = 1'b1;
				end
				DIR_BACK_RIGHT: begin
					sim_lduty = faster_duty(c.speed);
					sim_lrev = 1'b1;
					sim_rrev = 1'b1;
				end
				default: sim_rrev = 1'b1;
			endcase
			sim_busy = 1'b1;
			if (sim_target == 16'd0) begin
				sim_busy = 1'b0;
				status = STAT_DONE;
			end
		end else begin
			sim_left = sim_left + {15'b0, c.left_pulse};
			sim_right = sim_right + {15'b0, c.right_pulse};
			if (sim_busy) begin
				if (sim_left >= sim_target || sim_right >= sim_target) begin
					sim_busy = 1'b0;
					status = STAT_DONE;
				end else if (sim_ticks <= 22'd1) begin
					sim_ticks = '0;
					sim_busy = 1'b0;
					status = STAT_TIMEOUT;
				end else begin
					sim_ticks = sim_ticks - 22'd1;
				end
			end
		end
		r.left_duty = sim_lduty;
		r.right_duty = sim_rduty;
		r.left_reverse = sim_lrev;
		r.right_reverse = sim_rrev;
		r.turning = sim_busy;
		r.turn_status = status;
		r.target_count = sim_target;
		r.left_count = sim_left;
		r.right_count = sim_right;
		return r;
	endfunction

	function automatic string show_rsp(rsp_t r);
		return $sformatf("duty %0d/%0d rev %b/%b turning %b status %0d target %0d count %0d/%0d",
			r.left_duty, r.right_duty, r.left_reverse, r.right_reverse, r.turning,
			r.turn_status, r.target_count, r.left_count, r.right_count);
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// check the response beat first, then predict the accepted command beat
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_turn_rsps.size() == 0) begin
				note_fault($sformatf("unexpected result: %s", show_rsp(rsp)));
			end else begin
				want = pending_turn_rsps.pop_front();
				if (rsp.left_duty !== want.left_duty || rsp.right_duty !== want.right_duty ||
						rsp.left_reverse !== want.left_reverse ||
						rsp.right_reverse !== want.right_reverse ||
						rsp.turning !== want.turning || rsp.turn_status !== want.turn_status ||
						rsp.target_count !== want.target_count ||
						rsp.left_count !== want.left_count ||
						rsp.right_count !== want.right_count)
					note_fault($sformatf("result mismatch\n  exp %s\n  got %s",
						show_rsp(want), show_rsp(rsp)));
			end
		end
		if (arst_n && cmd_valid && cmd_ready)
			pending_turn_rsps.push_back(advance_turn(cmd));
	end

	// receiver: stall pattern reloaded after bit 15 is used, bit 0 always ready
	always @(posedge clk) begin
		if (calm)
			rsp_ready <= 1'b1;
		else
			rsp_ready <= stall_pat[stall_pos];
		if (stall_pos == 15) begin
			stall_pos <= 0;
			stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0001);
		end else begin
			stall_pos <= stall_pos + 1;
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic cmd_t random_cmd();
		logic [31:0] raw;
		cmd_t c;
		raw = $urandom;
		c = raw[$bits(cmd_t)-1:0];
		return c;
	endfunction

	function automatic cmd_t start_cmd(logic [15:0] angle, logic [3:0] dir, logic [6:0] speed);
		cmd_t c;
		c = random_cmd();
		c.mode = MODE_START;
		c.turn_angle = angle;
		c.direction = dir;
		c.speed = speed;
		return c;
	endfunction

	function automatic cmd_t tick_cmd(logic lp, logic rp);
		cmd_t c;
		c = random_cmd();
		c.mode = MODE_TICK;
		c.left_pulse = lp;
		c.right_pulse = rp;
		return c;
	endfunction

	// called on a clock edge, returns on the edge where the beat is taken
	task automatic send_item(cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		burst_left--;
	endtask

	// one edge first so a beat taken on the calling edge is already queued
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_turn_rsps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_WHEEL_TO_CENTER: geo_wtc = val[15:0];
			REG_WHEEL_RADIUS: geo_radius = val[15:0];
			REG_COUNTS_PER_REV: geo_cpr = val[15:0];
			REG_TIMEOUT_TICKS: geo_timeout = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_geometry(logic [15:0] wtc, logic [15:0] radius, logic [15:0] cpr,
			logic [21:0] ticks_allowed);
		wait_drained();
		write_reg(REG_WHEEL_TO_CENTER, {6'b0, wtc});
		write_reg(REG_WHEEL_RADIUS, {6'b0, radius});
		write_reg(REG_COUNTS_PER_REV, {6'b0, cpr});
		write_reg(REG_TIMEOUT_TICKS, ticks_allowed);
	endtask

	task automatic test_idle_ticks();
		send_item(tick_cmd(1'b0, 1'b0));
		send_item(tick_cmd(1'b1, 1'b0));
		send_item(tick_cmd(1'b0, 1'b1));
		send_item(tick_cmd(1'b1, 1'b1));
	endtask

	task automatic test_zero_target();
		send_item(start_cmd(16'd0, DIR_CW, 7'd100));
	endtask

	// every direction code, each start dropping the turn before it
	task automatic test_directions();
		logic [6:0] speed_set [8];
		speed_set = '{7'd0, 7'd5, 7'd10, 7'd11, 7'd100, 7'd117, 7'd118, 7'd127};
		for (int d = 0; d < 16; d++)
			send_item(start_cmd(16'd3, 4'(d), speed_set[d % 8]));
	endtask

	task automatic test_reach_target();
		send_item(start_cmd(16'd1, DIR_FWD_LEFT, 7'd50));
		send_item(tick_cmd(1'b1, 1'b0));
		send_item(tick_cmd(1'b0, 1'b1));
		send_item(tick_cmd(1'b1, 1'b0));
		send_item(tick_cmd(1'b1, 1'b1));
	endtask

	task automatic test_config_extremes();
		// product wraps, quotient wider than the count
		apply_geometry(16'hFFFF, 16'd1, 16'hFFFF, 22'd2);
		send_item(start_cmd(16'hFFFF, DIR_BACK_RIGHT, 7'd127));
		repeat (3) send_item(tick_cmd(1'b0, 1'b0));
		// no ticks allowed
		apply_geometry(16'd100, 16'd35, 16'd360, 22'd0);
		send_item(start_cmd(16'd10, DIR_BACK_LEFT, 7'd0));
		send_item(tick_cmd(1'b0, 1'b0));
		send_item(tick_cmd(1'b1, 1'b1));
		// zero radius gives an all-ones target
		apply_geometry(16'd100, 16'd0, 16'd360, 22'd5);
		send_item(start_cmd(16'd1, DIR_FWD_RIGHT, 7'd5));
		repeat (6) send_item(tick_cmd(1'($urandom), 1'($urandom)));
		apply_geometry(16'd0, 16'hFFFF, 16'd0, 22'd1);
		send_item(start_cmd(16'hFFFF, DIR_CCW, 7'd64));
		send_item(tick_cmd(1'b1, 1'b1));
	endtask

	// back-to-back idle ticks after a turn that ends on its command
	task automatic test_idle_run();
		apply_geometry(WTC_RESET, RADIUS_RESET, CPR_RESET, TIMEOUT_RESET);
		calm = 1'b1;
		send_item(start_cmd(16'd0, DIR_BACK, 7'd100));
		repeat (40) send_item(tick_cmd(1'b1, 1'b1));
		wait_drained();
		calm = 1'b0;
	endtask

	task automatic run_random_phase(logic [15:0] wtc, logic [15:0] radius, logic [15:0] cpr,
			logic [21:0] ticks_allowed, int angle_max, int n_items, logic quiet);
		int sent;
		int run;
		int noise;
		int unsigned rate;
		logic [15:0] angle;
		apply_geometry(wtc, radius, cpr, ticks_allowed);
		calm = quiet;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				// a turn followed by a run of ticks at some pulse rate
				if ($urandom_range(0, 5) == 0)
					angle = 16'($urandom);
				else
					angle = 16'($urandom_range(0, angle_max));
				send_item(start_cmd(angle, 4'($urandom), 7'($urandom)));
				run = $urandom_range(0, 70);
				rate = $urandom_range(0, 4);
				repeat (run)
					send_item(tick_cmd($urandom_range(0, 3) < rate, $urandom_range(0, 3) < rate));
				sent += run + 1;
			end else begin
				noise = $urandom_range(1, 5);
				repeat (noise) send_item(random_cmd());
				sent += noise;
			end
		end
		wait_drained();
		calm = 1'b0;
	endtask

	task automatic test_random_turns();
		run_random_phase(16'd100, 16'd35, 16'd360, 22'd60, 20, 200, 1'b0);
		run_random_phase(16'd10, 16'd1, 16'd36, 22'd40, 40, 160, 1'b1);
		run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 22'h3FFFFF, 8, 140, 1'b0);
		run_random_phase(16'd0, 16'd1, 16'd0, 22'd1, 30, 100, 1'b0);
		run_random_phase(16'd360, 16'd2, 16'd1, 22'd25, 60, 160, 1'b0);
		run_random_phase(16'd50, 16'd0, 16'd100, 22'd10, 10, 100, 1'b0);
		run_random_phase(16'd1, 16'hFFFF, 16'd1, 22'd3, 30, 100, 1'b0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_zero_target();
		test_directions();
		test_reach_target();
		test_config_extremes();
		test_idle_run();
		test_random_turns();
		wait_drained();
		repeat (40) @(posedge clk);
		if (fault_count == 0 && pending_turn_rsps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hw/rtl/etba_pkg.sv
hw/rtl/etba_div.sv
hw/rtl/encoder_turn_by_angle.sv
verif/tb.sv
